>>> src/alllm_pkg.sv
package alllm_pkg;

    localparam int TYPE_W   = 2;
    localparam int IDX_W    = 8;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INS_AFTER  = 2'd0,
        REQ_INS_BEFORE = 2'd1,
        REQ_INS_FRONT  = 2'd2,
        REQ_DELETE     = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SLOT = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_STEP2,
        S_STEP3,
        S_FIN
    } ctrl_state_t;

    // per-field write enables of the link store
    typedef struct packed {
        logic next_we;
        logic prev_we;
        logic used_we;
        logic value_we;
    } link_we_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   used_slot;
        logic [IDX_W-1:0]   head_slot;
        logic [IDX_W-1:0]   tail_slot;
        logic [COUNT_W-1:0] element_count;
    } result_t;

endpackage

>>> src/alllm_if.sv
interface alllm_req_if;
    logic                               valid;
    logic                               ready;
    logic [alllm_pkg::TYPE_W-1:0]       req_type;
    logic [alllm_pkg::IDX_W-1:0]        slot_index;
    logic signed [alllm_pkg::ITEM_W-1:0] item_value;

    modport source (output valid, req_type, slot_index, item_value, input ready);
    modport sink   (input valid, req_type, slot_index, item_value, output ready);
endinterface

interface alllm_res_if;
    logic                           valid;
    logic                           ready;
    logic [alllm_pkg::STATUS_W-1:0] status;
    logic [alllm_pkg::IDX_W-1:0]    used_slot;
    logic [alllm_pkg::IDX_W-1:0]    head_slot;
    logic [alllm_pkg::IDX_W-1:0]    tail_slot;
    logic [alllm_pkg::COUNT_W-1:0]  element_count;

    modport source (output valid, status, used_slot, head_slot, tail_slot, element_count,
                    input ready);
    modport sink   (input valid, status, used_slot, head_slot, tail_slot, element_count,
                    output ready);
endinterface

>>> src/alllm_link_ram.sv
module alllm_link_ram #(
    parameter int SLOT_COUNT  = 256,
    parameter int VALUE_WIDTH = 32,
    localparam int AW         = $clog2(SLOT_COUNT)
) (
    input  logic                   clk,
    input  alllm_pkg::link_we_t    we,
    input  logic [AW-1:0]          wr_addr,
    input  logic [AW-1:0]          wr_next,
    input  logic [AW-1:0]          wr_prev,
    input  logic                   wr_used,
    input  logic [VALUE_WIDTH-1:0] wr_value,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic [AW-1:0]          rd_next,
    output logic [AW-1:0]          rd_prev,
    output logic                   rd_used
);
    import alllm_pkg::*;

    logic [AW-1:0]          next_mem  [SLOT_COUNT];
    logic [AW-1:0]          prev_mem  [SLOT_COUNT];
    logic                   used_mem  [SLOT_COUNT];
    logic [VALUE_WIDTH-1:0] value_mem [SLOT_COUNT];

    logic [AW-1:0] rd_next_reg;
    logic [AW-1:0] rd_prev_reg;
    logic          rd_used_reg;

    // one write port with field enables, one registered read port
    always_ff @(posedge clk)
    begin
        if (we.next_we)
        begin
            next_mem[wr_addr] <= wr_next;
        end
        if (we.prev_we)
        begin
            prev_mem[wr_addr] <= wr_prev;
        end
        if (we.used_we)
        begin
            used_mem[wr_addr] <= wr_used;
        end
        if (we.value_we)
        begin
            value_mem[wr_addr] <= wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
            rd_used_reg <= used_mem[rd_addr];
        end
    end

    assign rd_next = rd_next_reg;
    assign rd_prev = rd_prev_reg;
    assign rd_used = rd_used_reg;

endmodule

>>> src/alllm_ctrl.sv
module alllm_ctrl #(
    parameter int SLOT_COUNT  = 256,
    parameter int VALUE_WIDTH = 32,
    localparam int SW         = $clog2(SLOT_COUNT)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    alllm_req_if.sink              req,
    input  logic                   out_free,
    output logic                   res_load,
    output alllm_pkg::result_t     result,
    output alllm_pkg::link_we_t    we,
    output logic [SW-1:0]          wr_addr,
    output logic [SW-1:0]          wr_next,
    output logic [SW-1:0]          wr_prev,
    output logic                   wr_used,
    output logic [VALUE_WIDTH-1:0] wr_value,
    output logic                   rd_en,
    output logic [SW-1:0]          rd_addr,
    input  logic [SW-1:0]          rd_next,
    input  logic [SW-1:0]          rd_prev,
    input  logic                   rd_used
);
    import alllm_pkg::*;

    localparam logic [SW-1:0] SENTINEL  = '0;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    ctrl_state_t state_reg, state_next;

    logic [SW-1:0]          clr_reg,   clr_next;
    logic [SW-1:0]          head_reg,  head_next;
    logic [SW-1:0]          tail_reg,  tail_next;
    logic [SW-1:0]          free_reg,  free_next;
    logic [SW-1:0]          count_reg, count_next;

    req_kind_t              kind_reg,  kind_next;
    logic [SW-1:0]          slot_reg,  slot_next;
    logic                   range_reg, range_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [SW-1:0]          left_reg,  left_next;
    logic [SW-1:0]          right_reg, right_next;
    logic [SW-1:0]          fslot_reg, fslot_next;
    status_t                status_reg, status_next;
    logic [SW-1:0]          used_reg,  used_next;

    logic        accept;
    logic        in_range;
    logic        is_del;
    logic        anchor_ok;
    status_t     look_status;
    logic [SW-1:0] ins_left;
    logic [SW-1:0] ins_right;

    assign accept   = req.valid && req.ready;
    assign in_range = (32'(req.slot_index) < SLOT_COUNT);
    assign is_del   = (kind_reg == REQ_DELETE);

    // anchor check and neighbour choice, valid in S_LOOK once the anchor entry is read
    always_comb
    begin
        anchor_ok = range_reg && ((slot_reg == SENTINEL) ? !is_del : rd_used);
        if (!anchor_ok)
        begin
            look_status = ST_BAD_SLOT;
        end
        else if (!is_del && (free_reg == SENTINEL))
        begin
            look_status = ST_FULL;
        end
        else
        begin
            look_status = ST_OK;
        end

        case (kind_reg)
            REQ_INS_AFTER:
            begin
                ins_left  = slot_reg;
                ins_right = (slot_reg == SENTINEL) ? head_reg : rd_next;
            end
            REQ_INS_BEFORE:
            begin
                ins_left  = (slot_reg == SENTINEL) ? tail_reg : rd_prev;
                ins_right = slot_reg;
            end
            REQ_INS_FRONT:
            begin
                ins_left  = SENTINEL;
                ins_right = head_reg;
            end
            default:
            begin
                ins_left  = rd_prev;
                ins_right = rd_next;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = (look_status == ST_OK) ? S_STEP2 : S_FIN;
            end
            S_STEP2:
            begin
                state_next = S_STEP3;
            end
            S_STEP3:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = accept ? S_LOOK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs: handshake and memory port control
    always_comb
    begin
        req.ready = 1'b0;
        res_load  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = SW'(req.slot_index);
        we        = '0;
        wr_addr   = slot_reg;
        wr_next   = '0;
        wr_prev   = '0;
        wr_used   = 1'b0;
        wr_value  = value_reg;

        case (state_reg)
            S_CLEAR:
            begin
                we.next_we = 1'b1;
                we.prev_we = 1'b1;
                we.used_we = 1'b1;
                wr_addr    = clr_reg;
                wr_next    = ((clr_reg == SENTINEL) || (clr_reg == LAST_SLOT))
                             ? SENTINEL : clr_reg + SW'(1);
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                rd_en     = req.valid && in_range;
            end
            S_LOOK:
            begin
                if (look_status == ST_OK)
                begin
                    if (is_del)
                    begin
                        // freed slot goes to the front of the free chain
                        we.next_we = 1'b1;
                        we.prev_we = 1'b1;
                        we.used_we = 1'b1;
                        wr_addr    = slot_reg;
                        wr_next    = free_reg;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = free_reg;
                        if (ins_left != SENTINEL)
                        begin
                            we.next_we = 1'b1;
                            wr_addr    = ins_left;
                            wr_next    = free_reg;
                        end
                    end
                end
            end
            S_STEP2:
            begin
                if (is_del)
                begin
                    if (left_reg != SENTINEL)
                    begin
                        we.next_we = 1'b1;
                        wr_addr    = left_reg;
                        wr_next    = right_reg;
                    end
                end
                else
                begin
                    we.next_we  = 1'b1;
                    we.prev_we  = 1'b1;
                    we.used_we  = 1'b1;
                    we.value_we = 1'b1;
                    wr_addr     = fslot_reg;
                    wr_next     = right_reg;
                    wr_prev     = left_reg;
                    wr_used     = 1'b1;
                end
            end
            S_STEP3:
            begin
                if (right_reg != SENTINEL)
                begin
                    we.prev_we = 1'b1;
                    wr_addr    = right_reg;
                    wr_prev    = is_del ? left_reg : fslot_reg;
                end
            end
            S_FIN:
            begin
                req.ready = out_free;
                res_load  = out_free;
                rd_en     = out_free && req.valid && in_range;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // list registers and request payload
    always_comb
    begin
        clr_next    = clr_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        slot_next   = slot_reg;
        range_next  = range_reg;
        value_next  = value_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        fslot_next  = fslot_reg;
        status_next = status_reg;
        used_next   = used_reg;

        if (accept)
        begin
            kind_next  = req_kind_t'(req.req_type);
            slot_next  = SW'(req.slot_index);
            range_next = in_range;
            value_next = VALUE_WIDTH'($unsigned(req.item_value));
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + SW'(1);
            end
            S_LOOK:
            begin
                status_next = look_status;
                used_next   = SENTINEL;
                left_next   = ins_left;
                right_next  = ins_right;
                if (look_status == ST_OK)
                begin
                    if (is_del)
                    begin
                        free_next  = slot_reg;
                        count_next = count_reg - SW'(1);
                        used_next  = slot_reg;
                    end
                    else
                    begin
                        fslot_next = free_reg;
                        used_next  = free_reg;
                        if (ins_left == SENTINEL)
                        begin
                            head_next = free_reg;
                        end
                    end
                end
            end
            S_STEP2:
            begin
                if (is_del)
                begin
                    if (left_reg == SENTINEL)
                    begin
                        head_next = right_reg;
                    end
                end
                else
                begin
                    // read of the taken slot was issued in S_LOOK
                    free_next = rd_next;
                end
            end
            S_STEP3:
            begin
                if (right_reg == SENTINEL)
                begin
                    tail_next = is_del ? left_reg : fslot_reg;
                end
                if (!is_del)
                begin
                    count_next = count_reg + SW'(1);
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            free_reg  <= SW'(1);
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        slot_reg   <= slot_next;
        range_reg  <= range_next;
        value_reg  <= value_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        fslot_reg  <= fslot_next;
        status_reg <= status_next;
        used_reg   <= used_next;
    end

    assign result.status        = status_reg;
    assign result.used_slot     = IDX_W'(used_reg);
    assign result.head_slot     = IDX_W'(head_reg);
    assign result.tail_slot     = IDX_W'(tail_reg);
    assign result.element_count = COUNT_W'(count_reg);

endmodule

>>> src/array_linked_list_manager_core.sv
// A successful insert or delete runs through LOOK, STEP2, STEP3 and FIN before its
// result is registered at the output; a rejected one skips to FIN after LOOK.
// One request at a time, taken in IDLE or in FIN when the output register is free;
// a request needs up to three link updates on the link store's single write port.
// Reset: asynchronous, active low; then a clearing pass over every slot rebuilds
// the free chain, during which no request is taken.
module array_linked_list_manager_core #(
    parameter int SLOT_COUNT  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    alllm_req_if.sink   req,
    alllm_res_if.source res
);
    import alllm_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);

    // Organisation
    //  - alllm_link_ram holds next link, prev link, in-use flag and value per slot;
    //    one write (field enables) and one registered read per cycle.
    //  - Slot 0 is the sentinel: its links live in head/tail registers in the
    //    controller, so sentinel updates never cost a memory cycle.
    //  - alllm_ctrl sequences each request:
    //      LOOK  : anchor entry read back, validity and full checks;
    //              insert: read the free slot's next link, link the left neighbour;
    //              delete: rewrite the freed entry onto the free chain.
    //      STEP2 : insert: write the new entry; delete: relink the left neighbour.
    //      STEP3 : relink the right neighbour's prev link.
    //      FIN   : hand the result to the output register; may take the next request.
    //  - Requests never overlap, so no forwarding is needed: every write lands before
    //    the next request's first read.

    link_we_t               we;
    logic [SW-1:0]          wr_addr;
    logic [SW-1:0]          wr_next;
    logic [SW-1:0]          wr_prev;
    logic                   wr_used;
    logic [VALUE_WIDTH-1:0] wr_value;
    logic                   rd_en;
    logic [SW-1:0]          rd_addr;
    logic [SW-1:0]          rd_next;
    logic [SW-1:0]          rd_prev;
    logic                   rd_used;

    logic    out_free;
    logic    res_load;
    result_t result;

    // output register: holds one finished result while the controller moves on
    logic    res_valid_reg, res_valid_next;
    result_t res_data_reg;

    alllm_ctrl #(
        .SLOT_COUNT  (SLOT_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .res_load (res_load),
        .result   (result),
        .we       (we),
        .wr_addr  (wr_addr),
        .wr_next  (wr_next),
        .wr_prev  (wr_prev),
        .wr_used  (wr_used),
        .wr_value (wr_value),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_next  (rd_next),
        .rd_prev  (rd_prev),
        .rd_used  (rd_used)
    );

    alllm_link_ram #(
        .SLOT_COUNT  (SLOT_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_link_ram (
        .clk      (clk),
        .we       (we),
        .wr_addr  (wr_addr),
        .wr_next  (wr_next),
        .wr_prev  (wr_prev),
        .wr_used  (wr_used),
        .wr_value (wr_value),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_next  (rd_next),
        .rd_prev  (rd_prev),
        .rd_used  (rd_used)
    );

    // register is free when empty or being drained in this cycle
    assign out_free = !res_valid_reg || res.ready;

    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= result;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = res_data_reg.status;
    assign res.used_slot     = res_data_reg.used_slot;
    assign res.head_slot     = res_data_reg.head_slot;
    assign res.tail_slot     = res_data_reg.tail_slot;
    assign res.element_count = res_data_reg.element_count;

endmodule

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import alllm_pkg::*;

    // Slots in the block as instantiated; slot 0 is the sentinel.
    localparam int SLOTS = 256;
    // Long receiver hold-off, long enough to back the block up into its input.
    localparam int HOLD_CYCLES = 400;
    // Cycles with no transaction on either channel before the run is abandoned.
    // Covers the clearing pass after reset, the hold-off and long random gaps.
    localparam int STALL_LIMIT = 6000;
    // Quiet time after the last result, to catch anything spurious.
    localparam int DRAIN_CYCLES = 16;

    // ------------------------------------------------------------------
    // Shadow copy of the list: predicts every result and holds the ones
    // still awaited. Stored values never reach the result port, so only
    // the links, the valid bits, the free chain and the count are kept.
    // ------------------------------------------------------------------
    class list_shadow;
        logic [IDX_W-1:0]   fwd_link [SLOTS];
        logic [IDX_W-1:0]   back_link[SLOTS];
        bit                 live     [SLOTS];
        logic [IDX_W-1:0]   free_head;
        logic [COUNT_W-1:0] count;
        result_t            awaited[$];
        int                 error_count;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                fwd_link[i]  = (i == 0 || i == SLOTS - 1) ? '0 : IDX_W'(i + 1);
                back_link[i] = '0;
                live[i]      = 1'b0;
            end
            free_head   = IDX_W'(1);
            count       = '0;
            error_count = 0;
        endfunction

        // Apply one accepted request and queue the result it should give.
        function void note_request(req_kind_t kind, logic [IDX_W-1:0] idx);
            result_t          r;
            logic [IDX_W-1:0] f;
            logic [IDX_W-1:0] lft;
            logic [IDX_W-1:0] rgt;
            r.status    = ST_OK;
            r.used_slot = '0;
            if (kind == REQ_DELETE)
            begin
                if (idx == 0 || !live[idx])
                    r.status = ST_BAD_SLOT;
                else
                begin
                    lft = back_link[idx];
                    rgt = fwd_link[idx];
                    fwd_link[lft]  = rgt;
                    back_link[rgt] = lft;
                    fwd_link[idx]  = free_head;
                    back_link[idx] = '0;
                    live[idx]      = 1'b0;
                    free_head      = idx;
                    count          = count - 1'b1;
                    r.used_slot    = idx;
                end
            end
            else if (idx != 0 && !live[idx])
                r.status = ST_BAD_SLOT;
            else if (free_head == 0)
                r.status = ST_FULL;
            else
            begin
                f         = free_head;
                free_head = fwd_link[f];
                live[f]   = 1'b1;
                case (kind)
                    REQ_INS_AFTER:
                    begin
                        lft = idx;
                        rgt = fwd_link[idx];
                    end
                    REQ_INS_BEFORE:
                    begin
                        lft = back_link[idx];
                        rgt = idx;
                    end
                    default:
                    begin
                        lft = '0;
                        rgt = fwd_link[0];
                    end
                endcase
                fwd_link[lft]  = f;
                fwd_link[f]    = rgt;
                back_link[f]   = lft;
                back_link[rgt] = f;
                count          = count + 1'b1;
                r.used_slot    = f;
            end
            r.head_slot     = fwd_link[0];
            r.tail_slot     = back_link[0];
            r.element_count = count;
            awaited.push_back(r);
        endfunction

        function void compare_field(string what, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                error_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, got.status, got.used_slot);
                error_count++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("used_slot", want.used_slot, got.used_slot);
            compare_field("head_slot", want.head_slot, got.head_slot);
            compare_field("tail_slot", want.tail_slot, got.tail_slot);
            compare_field("element_count", want.element_count, got.element_count);
        endfunction

        // Random element slot, or the sentinel when the list is empty.
        function logic [IDX_W-1:0] any_live_slot();
            int start;
            int s;
            start = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++)
            begin
                s = (start + k) % SLOTS;
                if (s != 0 && live[s])
                    return IDX_W'(s);
            end
            return '0;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    alllm_req_if req_ch();
    alllm_res_if res_ch();

    array_linked_list_manager_core #(
        .SLOT_COUNT  (SLOTS),
        .VALUE_WIDTH (ITEM_W)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    list_shadow shadow = new();

    // Idle percentages for each side, and the current stimulus phase.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int phase       = 0;
    int stall_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Every input known from time zero; reset asserted at the start, then released.
    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_INS_FRONT;
        req_ch.slot_index <= '0;
        req_ch.item_value <= '0;
        res_ch.ready      <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Request side. The shadow is updated by the driver itself as soon as
    // the transaction is seen, so the generator always works from the
    // list as it stands after every accepted request.
    // ------------------------------------------------------------------
    task automatic offer_request(input req_kind_t kind, input logic [IDX_W-1:0] idx,
                                 input logic signed [ITEM_W-1:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.slot_index <= idx;
        req_ch.item_value <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        shadow.note_request(kind, idx);
    endtask

    // Hand-picked requests: every kind, rejected anchors, sentinel anchors
    // and the extremes of the value. Slot numbers follow from the free
    // chain starting at slot 1 after reset.
    task automatic directed_requests();
        offer_request(REQ_DELETE,     8'd0,   32'sd0);          // delete of the sentinel
        offer_request(REQ_DELETE,     8'd5,   32'sd0);          // delete of a free slot
        offer_request(REQ_INS_AFTER,  8'd7,   32'sd12);         // anchor not in use
        offer_request(REQ_INS_FRONT,  8'd200, 32'sd3);          // front insert, bad anchor
        offer_request(REQ_INS_FRONT,  8'd0,   32'h7FFF_FFFF);   // first element, slot 1
        offer_request(REQ_INS_AFTER,  8'd0,   32'h8000_0000);   // after sentinel = front
        offer_request(REQ_INS_BEFORE, 8'd0,   -32'sd1);         // before sentinel = append
        offer_request(REQ_INS_AFTER,  8'd1,   32'sd0);          // middle insert
        offer_request(REQ_INS_BEFORE, 8'd2,   32'sd1);          // new head via before
        offer_request(REQ_INS_FRONT,  8'd3,   32'h5A5A_A5A5);   // front, valid anchor
        offer_request(REQ_DELETE,     8'd255, 32'sd0);          // top slot, still free
        offer_request(REQ_DELETE,     8'd3,   32'sd0);          // tail
        offer_request(REQ_DELETE,     8'd5,   32'sd0);          // second element
        offer_request(REQ_INS_AFTER,  8'd4,   32'sd77);         // reuses a freed slot
        offer_request(REQ_DELETE,     8'd1,   32'sd0);          // middle
        offer_request(REQ_INS_BEFORE, 8'd255, 32'sd9);          // anchor not in use
        offer_request(REQ_INS_BEFORE, 8'd4,   32'sd8);
        offer_request(REQ_DELETE,     8'd1,   32'sd0);          // slot 1, back in use since the insert above
        offer_request(REQ_INS_AFTER,  8'd255, -32'sd2);
    endtask

    // Random requests. The list alternates between filling (mostly
    // inserts, until it has stood full for a while) and draining (mostly
    // deletes, until empty), so the full case and the empty list are both
    // reached repeatedly. A share of transactions is pure noise.
    bit filling     = 1'b1;
    int full_streak = 0;

    task automatic random_requests(input int n_items);
        req_kind_t            kind;
        logic [IDX_W-1:0]     idx;
        logic signed [ITEM_W-1:0] val;
        bit                   do_insert;
        for (int i = 0; i < n_items; i++)
        begin
            val = $urandom;
            if ($urandom_range(0, 99) < 8)
            begin
                kind = req_kind_t'($urandom_range(0, 3));
                idx  = IDX_W'($urandom_range(0, SLOTS - 1));
            end
            else
            begin
                do_insert = filling ? ($urandom_range(0, 99) < 88)
                                    : ($urandom_range(0, 99) < 12);
                if (do_insert)
                begin
                    kind = req_kind_t'($urandom_range(0, 2));
                    idx  = ($urandom_range(0, 5) == 0) ? '0 : shadow.any_live_slot();
                end
                else
                begin
                    kind = REQ_DELETE;
                    idx  = (shadow.count == 0) ? IDX_W'($urandom_range(1, SLOTS - 1))
                                               : shadow.any_live_slot();
                end
            end
            offer_request(kind, idx, val);
            if (shadow.free_head == 0)
                full_streak++;
            if (full_streak > 6)
            begin
                filling     = 1'b0;
                full_streak = 0;
            end
            if (shadow.count == 0)
                filling = 1'b1;
        end
    endtask

    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // Phase 0: sender mostly busy, receiver mostly stalling.
        phase       = 0;
        tx_idle_pct = 11;
        rx_idle_pct = 79;
        directed_requests();
        random_requests(420);

        // Phase 1: the other way round.
        phase       = 1;
        tx_idle_pct = 79;
        rx_idle_pct = 11;
        random_requests(430);

        // Phase 2: no idling; the receiver's long hold-off falls here.
        phase       = 2;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_requests(430);

        @(posedge clk);
        req_ch.valid <= 1'b0;
        while (shadow.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.error_count == 0 && shadow.awaited.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off at the start of
    // the last phase while the sender keeps offering.
    // ------------------------------------------------------------------
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (phase == 2 && !held)
            begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Result monitor: samples the pre-edge values of the channel.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.status        = status_t'(res_ch.status);
            got.used_slot     = res_ch.used_slot;
            got.head_slot     = res_ch.head_slot;
            got.tail_slot     = res_ch.tail_slot;
            got.element_count = res_ch.element_count;
            shadow.check_result(got);
        end
    end

    // Watchdog: any transaction on either channel resets the count.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
    end

    initial
    begin
        while (stall_count < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, shadow.awaited.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> files.f
src/alllm_pkg.sv
src/alllm_if.sv
src/alllm_link_ram.sv
src/alllm_ctrl.sv
src/array_linked_list_manager_core.sv
bench/tb_top.sv
